// ----- design/sprlm_pkg.sv -----
package sprlm_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int COUNT_BITS    = 16;
    localparam int TALLY_BITS    = COUNT_BITS + 1;
    localparam int SQ_BITS       = 2 * SAMPLE_BITS;
    localparam int SUM_BITS      = 63;

    localparam int CFG_ADDR_BITS = 1;
    localparam int CFG_DATA_BITS = SAMPLE_BITS;

    localparam int IN_DATA_BITS  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_FLD_BITS  = 6 * SAMPLE_BITS + 2;
    localparam int OUT_DATA_BITS = ((OUT_FLD_BITS + 7) / 8) * 8;

    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_LVL_BITS = $clog2(QUEUE_DEPTH + 1);

    // restoring divide: one quotient bit per cycle; root: one result bit per cycle
    localparam int DIV_STEPS     = SUM_BITS;
    localparam int SQRT_STEPS    = (SUM_BITS + 1) / 2;
    localparam int STEP_BITS     = $clog2(DIV_STEPS);
    localparam int SQRT_IDX_BITS = $clog2(SQRT_STEPS);

    // 0.99 of full scale, rounded up
    localparam logic [SAMPLE_BITS-1:0] CLIP_RESET =
        SAMPLE_BITS'((99 * (64'd1 << (SAMPLE_BITS - 1)) + 99) / 100);
    localparam logic [TALLY_BITS-1:0] TALLY_LIMIT = {1'b1, {COUNT_BITS{1'b0}}};

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_CHANNEL_MODE   = 1'b0,
        REG_CLIP_THRESHOLD = 1'b1
    } t_cfg_reg;

    // finished block handed from the front to the back
    typedef struct packed {
        logic                   stereo;
        logic                   clip;
        logic                   ovf;
        logic [TALLY_BITS-1:0]  tally;
        logic [SAMPLE_BITS-1:0] lpeak;
        logic [SAMPLE_BITS-1:0] rpeak;
        logic [SUM_BITS-1:0]    lsum;
        logic [SUM_BITS-1:0]    rsum;
    } t_snap;

    // last member sits in the lowest bits
    typedef struct packed {
        logic                   count_overflow;
        logic                   clip_seen;
        logic [SAMPLE_BITS-1:0] rms_level;
        logic [SAMPLE_BITS-1:0] peak_level;
        logic [SAMPLE_BITS-1:0] rms_right;
        logic [SAMPLE_BITS-1:0] rms_left;
        logic [SAMPLE_BITS-1:0] peak_right;
        logic [SAMPLE_BITS-1:0] peak_left;
    } t_result;

    function automatic logic [SAMPLE_BITS-1:0] magnitude(input logic [SAMPLE_BITS-1:0] raw);
        return raw[SAMPLE_BITS-1] ? SAMPLE_BITS'(~raw + SAMPLE_BITS'(1)) : raw;
    endfunction

    function automatic logic [SUM_BITS-1:0] sum_sat(input logic [SUM_BITS-1:0] acc,
                                                    input logic [SQ_BITS-1:0]  sq);
        logic [SUM_BITS:0] s;
        s = {1'b0, acc} + (SUM_BITS + 1)'(sq);
        return s[SUM_BITS] ? {SUM_BITS{1'b1}} : s[SUM_BITS-1:0];
    endfunction

endpackage

// ----- design/sprlm_front.sv -----
module sprlm_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_accept,
    input  logic [sprlm_pkg::SAMPLE_BITS-1:0]     i_left,
    input  logic [sprlm_pkg::SAMPLE_BITS-1:0]     i_right,
    input  logic                                  i_last,
    input  logic                                  i_stereo,
    input  logic [sprlm_pkg::SAMPLE_BITS-1:0]     i_threshold,
    input  logic [sprlm_pkg::QUEUE_LVL_BITS-1:0]  i_q_level,
    output logic                                  o_ready,
    output logic                                  o_push,
    output sprlm_pkg::t_snap                      o_snap
);
    import sprlm_pkg::*;

    logic [SAMPLE_BITS-1:0] w_la, w_ra;
    logic [SQ_BITS-1:0]     w_lsq, w_rsq;

    logic                   r_s1_valid;
    logic                   r_s1_last;
    logic [SAMPLE_BITS-1:0] r_s1_la, r_s1_ra;
    logic [SQ_BITS-1:0]     r_s1_lsq, r_s1_rsq;

    logic [SAMPLE_BITS-1:0] r_lpeak, r_rpeak, n_lpeak, n_rpeak;
    logic [SUM_BITS-1:0]    r_lsum, r_rsum, n_lsum, n_rsum;
    logic [TALLY_BITS-1:0]  r_tally, n_tally;
    logic                   r_clip, r_ovf, n_clip, n_ovf;
    logic                   w_room;
    logic [QUEUE_LVL_BITS:0] w_claimed;

    // stage 0: magnitudes and squares
    assign w_la  = magnitude(i_left);
    assign w_ra  = magnitude(i_right);
    assign w_lsq = SQ_BITS'(w_la) * SQ_BITS'(w_la);
    assign w_rsq = SQ_BITS'(w_ra) * SQ_BITS'(w_ra);

    // slots taken now plus a block end still in stage 1
    assign w_claimed = {1'b0, i_q_level} + (QUEUE_LVL_BITS + 1)'(r_s1_valid & r_s1_last);
    assign o_ready   = w_claimed < (QUEUE_LVL_BITS + 1)'(QUEUE_DEPTH);

    // stage 1: accumulate
    always_comb begin
        w_room  = ~r_tally[COUNT_BITS];
        n_lpeak = (r_s1_la > r_lpeak) ? r_s1_la : r_lpeak;
        n_rpeak = (i_stereo && (r_s1_ra > r_rpeak)) ? r_s1_ra : r_rpeak;
        n_clip  = r_clip | (r_s1_la >= i_threshold) | (i_stereo & (r_s1_ra >= i_threshold));
        n_lsum  = w_room ? sum_sat(r_lsum, r_s1_lsq) : r_lsum;
        n_rsum  = (w_room && i_stereo) ? sum_sat(r_rsum, r_s1_rsq) : r_rsum;
        n_tally = w_room ? TALLY_BITS'(r_tally + TALLY_BITS'(1)) : r_tally;
        n_ovf   = r_ovf | ~w_room;
    end

    assign o_push       = r_s1_valid & r_s1_last;
    assign o_snap.stereo = i_stereo;
    assign o_snap.clip  = n_clip;
    assign o_snap.ovf   = n_ovf;
    assign o_snap.tally = n_tally;
    assign o_snap.lpeak = n_lpeak;
    assign o_snap.rpeak = n_rpeak;
    assign o_snap.lsum  = n_lsum;
    assign o_snap.rsum  = n_rsum;

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_la   <= w_la;
            r_s1_ra   <= w_ra;
            r_s1_lsq  <= w_lsq;
            r_s1_rsq  <= w_rsq;
            r_s1_last <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_lpeak    <= '0;
            r_rpeak    <= '0;
            r_lsum     <= '0;
            r_rsum     <= '0;
            r_tally    <= '0;
            r_clip     <= 1'b0;
            r_ovf      <= 1'b0;
        end else begin
            r_s1_valid <= i_accept;
            if (r_s1_valid) begin
                if (r_s1_last) begin
                    r_lpeak <= '0;
                    r_rpeak <= '0;
                    r_lsum  <= '0;
                    r_rsum  <= '0;
                    r_tally <= '0;
                    r_clip  <= 1'b0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_lpeak <= n_lpeak;
                    r_rpeak <= n_rpeak;
                    r_lsum  <= n_lsum;
                    r_rsum  <= n_rsum;
                    r_tally <= n_tally;
                    r_clip  <= n_clip;
                    r_ovf   <= n_ovf;
                end
            end
        end
    end

    a_tally_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tally <= TALLY_LIMIT)
        else $error("frame tally beyond saturation limit");

endmodule

// ----- design/sprlm_queue.sv -----
module sprlm_queue (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_push,
    input  sprlm_pkg::t_snap                      i_data,
    input  logic                                  i_pop,
    output sprlm_pkg::t_snap                      o_data,
    output logic                                  o_empty,
    output logic [sprlm_pkg::QUEUE_LVL_BITS-1:0]  o_level
);
    import sprlm_pkg::*;

    t_snap                     r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_LVL_BITS-1:0] r_level;

    function automatic logic [QUEUE_PTR_BITS-1:0] ptr_inc(input logic [QUEUE_PTR_BITS-1:0] p);
        return (p == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : QUEUE_PTR_BITS'(p + 1'b1);
    endfunction

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_level == '0);
    assign o_level = r_level;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= ptr_inc(r_wr_ptr);
            if (i_pop)  r_rd_ptr <= ptr_inc(r_rd_ptr);
            if (i_push && !i_pop)      r_level <= QUEUE_LVL_BITS'(r_level + 1'b1);
            else if (!i_push && i_pop) r_level <= QUEUE_LVL_BITS'(r_level - 1'b1);
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |-> (r_level < QUEUE_LVL_BITS'(QUEUE_DEPTH)))
        else $error("block queue overrun");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty block queue");

endmodule

// ----- design/sprlm_root.sv -----
module sprlm_root (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [sprlm_pkg::SUM_BITS-1:0]     i_sum,
    input  logic [sprlm_pkg::TALLY_BITS-1:0]   i_count,
    output logic                               o_done,
    output logic [sprlm_pkg::SAMPLE_BITS-1:0]  o_root
);
    import sprlm_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_SQRT, ST_DONE} t_state;

    t_state                r_state;
    logic [STEP_BITS-1:0]  r_step;
    logic [SUM_BITS-1:0]   r_num;   // dividend, then quotient, then root remainder
    logic [SUM_BITS-1:0]   r_res;
    logic [TALLY_BITS-1:0] r_rem, r_den;

    logic [TALLY_BITS:0]   w_shift;
    logic                  w_div_ge;
    logic [TALLY_BITS-1:0] w_div_rem;
    logic [SUM_BITS-1:0]   w_div_num;
    logic [SUM_BITS-1:0]   w_bit;
    logic [SUM_BITS:0]     w_trial;
    logic                  w_sq_ge;
    logic [SUM_BITS-1:0]   w_sq_num, w_sq_res;

    always_comb begin
        w_shift   = {r_rem, r_num[SUM_BITS-1]};
        w_div_ge  = w_shift >= {1'b0, r_den};
        w_div_rem = w_div_ge ? TALLY_BITS'(w_shift - {1'b0, r_den}) : w_shift[TALLY_BITS-1:0];
        w_div_num = {r_num[SUM_BITS-2:0], w_div_ge};

        w_bit    = SUM_BITS'(1) << {r_step[SQRT_IDX_BITS-1:0], 1'b0};
        w_trial  = {1'b0, r_res} + {1'b0, w_bit};
        w_sq_ge  = {1'b0, r_num} >= w_trial;
        w_sq_num = w_sq_ge ? SUM_BITS'({1'b0, r_num} - w_trial) : r_num;
        w_sq_res = w_sq_ge ? SUM_BITS'((r_res >> 1) + w_bit) : (r_res >> 1);
    end

    assign o_done = (r_state == ST_DONE);
    assign o_root = r_res[SAMPLE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state) inside
                ST_IDLE, ST_DONE: begin
                    if (i_start) begin
                        r_num   <= i_sum;
                        r_den   <= i_count;
                        r_rem   <= '0;
                        r_step  <= STEP_BITS'(DIV_STEPS - 1);
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_num <= w_div_num;
                    r_rem <= w_div_rem;
                    if (r_step == '0) begin
                        r_res   <= '0;
                        r_step  <= STEP_BITS'(SQRT_STEPS - 1);
                        r_state <= ST_SQRT;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                ST_SQRT: begin
                    r_num <= w_sq_num;
                    r_res <= w_sq_res;
                    if (r_step == '0) r_state <= ST_DONE;
                    else              r_step  <= r_step - 1'b1;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_root_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (r_res[SUM_BITS-1:SQRT_STEPS] == '0))
        else $error("square root wider than half the radicand");

endmodule

// ----- design/sprlm_back.sv -----
module sprlm_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  sprlm_pkg::t_snap      i_head,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output sprlm_pkg::t_result    o_result
);
    import sprlm_pkg::*;

    typedef enum logic {ST_IDLE, ST_RUN} t_state;

    t_state                 r_state;
    logic                   r_valid;
    t_result                r_result;
    logic                   r_stereo, r_clip, r_ovf;
    logic [SAMPLE_BITS-1:0] r_lpeak, r_rpeak;

    logic                   w_start;
    logic                   w_l_done, w_r_done;
    logic [SAMPLE_BITS-1:0] w_l_root, w_r_root;
    logic                   w_out_free;
    logic                   w_load;
    t_result                w_result;

    assign w_start    = (r_state == ST_IDLE) && !i_empty;
    assign o_pop      = w_start;
    assign w_out_free = !r_valid || i_ready;
    assign w_load     = (r_state == ST_RUN) && w_l_done && w_r_done && w_out_free;

    sprlm_root u_root_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_sum   (i_head.lsum),
        .i_count (i_head.tally),
        .o_done  (w_l_done),
        .o_root  (w_l_root)
    );

    sprlm_root u_root_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_sum   (i_head.rsum),
        .i_count (i_head.tally),
        .o_done  (w_r_done),
        .o_root  (w_r_root)
    );

    always_comb begin
        w_result.clip_seen      = r_clip;
        w_result.count_overflow = r_ovf;
        if (r_stereo) begin
            w_result.peak_left  = r_lpeak;
            w_result.peak_right = r_rpeak;
            w_result.rms_left   = w_l_root;
            w_result.rms_right  = w_r_root;
            w_result.peak_level = (r_lpeak > r_rpeak) ? r_lpeak : r_rpeak;
            w_result.rms_level  = (w_l_root > w_r_root) ? w_l_root : w_r_root;
        end else begin
            w_result.peak_left  = '0;
            w_result.peak_right = '0;
            w_result.rms_left   = '0;
            w_result.rms_right  = '0;
            w_result.peak_level = r_lpeak;
            w_result.rms_level  = w_l_root;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid  <= 1'b1;
                r_result <= w_result;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_start) begin
                        r_stereo <= i_head.stereo;
                        r_clip   <= i_head.clip;
                        r_ovf    <= i_head.ovf;
                        r_lpeak  <= i_head.lpeak;
                        r_rpeak  <= i_head.rpeak;
                        r_state  <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (w_load) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_lanes_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_l_done == w_r_done)
        else $error("left and right root lanes out of step");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> !$past(w_load))
        else $error("result overwritten while stalled");

endmodule

// ----- design/stereo_peak_rms_level_meter_core.sv -----
// Channel  | Dir | Handshake                       | Payload
// ---------+-----+---------------------------------+------------------------------------------
// config   | in  | i_cfg_wr_en                     | i_cfg_addr, i_cfg_wdata
// frames   | in  | i_s_axis_tvalid/o_s_axis_tready | i_s_axis_tdata, i_s_axis_tlast=last_frame
// levels   | out | o_m_axis_tvalid/i_m_axis_tready | o_m_axis_tdata
//
// Frames are taken one beat per cycle while the queue has room; square then accumulate is a two stage front.
// A finished block waits in a two entry queue; the back takes one block at a time and runs a
// restoring divide and then a square root for each channel, both channels in parallel, and
// blocks that arrive faster than the back finishes them stall the input once the queue fills.
// Synchronous active low reset clears all block state at once; no clearing pass.
module stereo_peak_rms_level_meter_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [sprlm_pkg::CFG_ADDR_BITS-1:0]   i_cfg_addr,
    input  logic [sprlm_pkg::CFG_DATA_BITS-1:0]   i_cfg_wdata,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // left_sample[23:0], right_sample[47:24]
    input  logic [sprlm_pkg::IN_DATA_BITS-1:0]    i_s_axis_tdata,
    input  logic                                  i_s_axis_tlast,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // peak_left[23:0], peak_right[47:24], rms_left[71:48], rms_right[95:72],
    // peak_level[119:96], rms_level[143:120], clip_seen[144], count_overflow[145]
    output logic [sprlm_pkg::OUT_DATA_BITS-1:0]   o_m_axis_tdata
);
    import sprlm_pkg::*;

    logic                      r_stereo;
    logic [SAMPLE_BITS-1:0]    r_threshold;

    logic                      w_ready, w_accept;
    logic                      w_push, w_pop, w_empty;
    logic [QUEUE_LVL_BITS-1:0] w_level;
    t_snap                     w_snap_in, w_head;
    t_result                   w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stereo    <= 1'b0;
            r_threshold <= CLIP_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                REG_CHANNEL_MODE:   r_stereo    <= i_cfg_wdata[0];
                REG_CLIP_THRESHOLD: r_threshold <= i_cfg_wdata[SAMPLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_s_axis_tready = w_ready;
    assign w_accept        = i_s_axis_tvalid & w_ready;

    sprlm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_left      (i_s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_right     (i_s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .i_last      (i_s_axis_tlast),
        .i_stereo    (r_stereo),
        .i_threshold (r_threshold),
        .i_q_level   (w_level),
        .o_ready     (w_ready),
        .o_push      (w_push),
        .o_snap      (w_snap_in)
    );

    sprlm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_snap_in),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_empty (w_empty),
        .o_level (w_level)
    );

    sprlm_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (w_result)
    );

    assign o_m_axis_tdata = OUT_DATA_BITS'(w_result);

endmodule
